/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the sigmoid layer backprop RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge, switched off while reset is high.
`define ASSERT_CLK(lbl, clk_i, rst_i, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (rst_i) prop) \
    else $error("assertion failed");

// Condition that must never be true outside reset.
`define ASSERT_NEVER(lbl, clk_i, rst_i, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (rst_i) !(cond)) \
    else $error("forbidden condition seen");

`endif

/* hw/rtl/slbp_pkg.sv */
// Types and constants shared by the sigmoid layer backprop modules.
`timescale 1ns / 1ps

package slbp_pkg;

  localparam int DATA_W  = 16;
  localparam int LR_W    = 15;
  localparam int CMD_W   = 3;
  localparam int IDX_W   = 4;
  localparam int PADDR_W = 2;
  localparam int PDATA_W = 32;

  // Shared multiplier operand and product widths.
  localparam int MUL_A_W = 36;
  localparam int MUL_B_W = 17;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  localparam logic [LR_W-1:0]             LR_RESET = 15'd410;
  localparam logic [PADDR_W-1:0]          ADDR_LR  = 2'd0;
  localparam logic signed [MUL_B_W-1:0]   ONE_Q12  = 17'sd4096;

  localparam logic KIND_PASSBACK = 1'b0;
  localparam logic KIND_WEIGHT   = 1'b1;

  typedef enum logic [CMD_W-1:0] {
    CMD_WR_WEIGHT = 3'd0,
    CMD_WR_OUTPUT = 3'd1,
    CMD_WR_ERROR  = 3'd2,
    CMD_WR_ACT    = 3'd3,
    CMD_RUN       = 3'd4,
    CMD_RD_WEIGHT = 3'd5
  } cmd_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_D_RD,
    S_D_M1,
    S_D_M2,
    S_D_WR,
    S_P_RD,
    S_P_MUL,
    S_P_ACC,
    S_P_OUT,
    S_U_RD,
    S_U_M1,
    S_U_P,
    S_U_M2,
    S_U_CH,
    S_U_WR,
    S_R_RD,
    S_R_OUT
  } state_t;

  typedef enum logic [2:0] {
    MS_NONE,
    MS_E_O,
    MS_EO_OMC,
    MS_D_W,
    MS_D_X,
    MS_P_LR
  } mul_sel_t;

  typedef struct packed {
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     d_we;
    logic     acc_en;
    logic     acc_clr;
    logic     tmp_p;
    logic     tmp_ch;
    logic     w_upd_we;
    logic     emit_pb;
    logic     emit_rd;
    logic     sel_rd;
  } ctrl_t;

endpackage

/* hw/rtl/slbp_mul.sv */
// Shared signed multiplier with a registered product.
`timescale 1ns / 1ps

module slbp_mul (
  input  logic                                  clk,
  input  logic                                  en,
  input  logic signed [slbp_pkg::MUL_A_W-1:0]   a,
  input  logic signed [slbp_pkg::MUL_B_W-1:0]   b,
  output logic signed [slbp_pkg::MUL_P_W-1:0]   prod
);
  import slbp_pkg::*;

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= a * b;
    end
  end

endmodule

/* hw/rtl/slbp_ctrl.sv */
// Sequencer that walks the delta, pass-back and weight update phases, and the weight read.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module slbp_ctrl #(
  parameter int IN_SIZE  = 16,
  parameter int OUT_SIZE = 16,
  localparam int RW = (IN_SIZE > 1) ? $clog2(IN_SIZE) : 1,
  localparam int CW = (OUT_SIZE > 1) ? $clog2(OUT_SIZE) : 1,
  localparam int AW = (IN_SIZE * OUT_SIZE > 1) ? $clog2(IN_SIZE * OUT_SIZE) : 1
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [slbp_pkg::CMD_W-1:0]   command,
  output logic                         busy,
  output slbp_pkg::ctrl_t              ctl,
  output logic [RW-1:0]                row_cnt,
  output logic [CW-1:0]                col_cnt,
  output logic [AW-1:0]                w_addr
);
  import slbp_pkg::*;

  state_t state;
  state_t state_next;
  logic   c_last;
  logic   r_last;

  assign c_last = (col_cnt == CW'(OUT_SIZE - 1));
  assign r_last = (row_cnt == RW'(IN_SIZE - 1));
  assign busy   = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Weight address runs row-major alongside the row and column counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_cnt <= '0;
      col_cnt <= '0;
      w_addr  <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start && command == CMD_RUN) begin
            row_cnt <= '0;
            col_cnt <= '0;
            w_addr  <= '0;
          end
        end
        S_D_WR: begin
          col_cnt <= c_last ? '0 : col_cnt + CW'(1);
        end
        S_P_ACC: begin
          col_cnt <= c_last ? '0 : col_cnt + CW'(1);
          w_addr  <= w_addr + AW'(1);
        end
        S_P_OUT: begin
          if (r_last) begin
            row_cnt <= '0;
            w_addr  <= '0;
          end else begin
            row_cnt <= row_cnt + RW'(1);
          end
        end
        S_U_WR: begin
          w_addr <= w_addr + AW'(1);
          if (c_last) begin
            col_cnt <= '0;
            row_cnt <= r_last ? '0 : row_cnt + RW'(1);
          end else begin
            col_cnt <= col_cnt + CW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start && command == CMD_RUN) begin
          state_next = S_D_RD;
        end else if (start && command == CMD_RD_WEIGHT) begin
          state_next = S_R_RD;
        end
      end
      S_D_RD:  state_next = S_D_M1;
      S_D_M1:  state_next = S_D_M2;
      S_D_M2:  state_next = S_D_WR;
      S_D_WR:  state_next = c_last ? S_P_RD : S_D_RD;
      S_P_RD:  state_next = S_P_MUL;
      S_P_MUL: state_next = S_P_ACC;
      S_P_ACC: state_next = c_last ? S_P_OUT : S_P_RD;
      S_P_OUT: state_next = r_last ? S_U_RD : S_P_RD;
      S_U_RD:  state_next = S_U_M1;
      S_U_M1:  state_next = S_U_P;
      S_U_P:   state_next = S_U_M2;
      S_U_M2:  state_next = S_U_CH;
      S_U_CH:  state_next = S_U_WR;
      S_U_WR:  state_next = (c_last && r_last) ? S_IDLE : S_U_RD;
      S_R_RD:  state_next = S_R_OUT;
      S_R_OUT: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    case (state)
      S_IDLE: begin
        ctl.acc_clr = 1'b1;
      end
      S_D_M1: begin
        ctl.mul_en  = 1'b1;
        ctl.mul_sel = MS_E_O;
      end
      S_D_M2: begin
        ctl.mul_en  = 1'b1;
        ctl.mul_sel = MS_EO_OMC;
      end
      S_D_WR: begin
        ctl.d_we = 1'b1;
      end
      S_P_MUL: begin
        ctl.mul_en  = 1'b1;
        ctl.mul_sel = MS_D_W;
      end
      S_P_ACC: begin
        ctl.acc_en = 1'b1;
      end
      S_P_OUT: begin
        ctl.emit_pb = 1'b1;
        ctl.acc_clr = 1'b1;
      end
      S_U_M1: begin
        ctl.mul_en  = 1'b1;
        ctl.mul_sel = MS_D_X;
      end
      S_U_P: begin
        ctl.tmp_p = 1'b1;
      end
      S_U_M2: begin
        ctl.mul_en  = 1'b1;
        ctl.mul_sel = MS_P_LR;
      end
      S_U_CH: begin
        ctl.tmp_ch = 1'b1;
      end
      S_U_WR: begin
        ctl.w_upd_we = 1'b1;
      end
      S_R_RD: begin
        ctl.sel_rd = 1'b1;
      end
      S_R_OUT: begin
        ctl.emit_rd = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // A row of the pass-back sum always ends after the last column wrapped.
  `ASSERT_CLK(a_row_end_col_zero, clk, rst, (state == S_P_OUT) |-> (col_cnt == '0))
  // The sequencer only leaves a busy phase from the end of an update or a read.
  `ASSERT_CLK(a_busy_exit, clk, rst, $fell(busy) && !$past(rst) |-> ($past(state) == S_U_WR || $past(state) == S_R_OUT))

endmodule

/* hw/rtl/sigmoid_layer_backprop.sv */
// Top level of the sigmoid dense layer backpropagation engine.
//
//   Channel   Signals                                       Direction
//   config    psel penable pwrite paddr pwdata prdata pready APB slave, learning_rate at 0x0
//   command   start busy command row col value              in, taken on start && !busy
//   result    strobe kind index data last                   out, valid for one cycle
//
// Load commands are written in the cycle they are accepted and never raise busy.
// A weight read keeps busy high through S_R_RD and S_R_OUT; its result is shown as busy falls.
// A run keeps busy high through the delta, pass-back and weight update phases, which are
// sequenced around the one shared multiplier and the single weight memory read port.
// Reset loads learning_rate with 410; the stores hold nothing valid until written.
// The result side cannot stall; each result is taken in the cycle it is shown.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sigmoid_layer_backprop #(
  parameter int IN_SIZE  = 16,
  parameter int OUT_SIZE = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [slbp_pkg::PADDR_W-1:0]        paddr,
  input  logic [slbp_pkg::PDATA_W-1:0]        pwdata,
  output logic [slbp_pkg::PDATA_W-1:0]        prdata,
  output logic                                pready,
  input  logic                                start,
  output logic                                busy,
  input  logic [slbp_pkg::CMD_W-1:0]          command,
  input  logic [slbp_pkg::IDX_W-1:0]          row,
  input  logic [slbp_pkg::IDX_W-1:0]          col,
  input  logic signed [slbp_pkg::DATA_W-1:0]  value,
  output logic                                strobe,
  output logic                                kind,
  output logic [slbp_pkg::IDX_W-1:0]          index,
  output logic signed [slbp_pkg::DATA_W-1:0]  data,
  output logic                                last
);
  import slbp_pkg::*;

  localparam int RW      = (IN_SIZE > 1) ? $clog2(IN_SIZE) : 1;
  localparam int CW      = (OUT_SIZE > 1) ? $clog2(OUT_SIZE) : 1;
  localparam int DEPTH   = IN_SIZE * OUT_SIZE;
  localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int ACC_W   = MUL_P_W + CW;
  localparam int DELTA_W = MUL_A_W;
  localparam int SAT_W   = 64;

  localparam logic signed [MUL_P_W-1:0] HALF_12  = MUL_P_W'(2048);
  localparam logic signed [MUL_P_W-1:0] HALF_24  = MUL_P_W'(8388608);
  localparam logic signed [ACC_W-1:0]   HALF_ACC = ACC_W'(8388608);
  localparam logic signed [SAT_W-1:0]   SAT_MAX  = 64'sd32767;
  localparam logic signed [SAT_W-1:0]   SAT_MIN  = -64'sd32768;

  function automatic logic signed [DATA_W-1:0] sat16(input logic signed [SAT_W-1:0] v);
    if (v > SAT_MAX) begin
      return DATA_W'(SAT_MAX);
    end else if (v < SAT_MIN) begin
      return DATA_W'(SAT_MIN);
    end
    return v[DATA_W-1:0];
  endfunction

  ctrl_t             ctl;
  logic [RW-1:0]     row_cnt;
  logic [CW-1:0]     col_cnt;
  logic [AW-1:0]     w_addr;

  logic [LR_W-1:0]   learning_rate;
  logic              accept;
  logic              row_ok;
  logic              col_ok;
  logic [RW-1:0]     row_a;
  logic [CW-1:0]     col_a;
  logic [AW-1:0]     ld_addr;
  logic              ld_w_we;
  logic              ld_o_we;
  logic              ld_e_we;
  logic              ld_x_we;

  logic [AW-1:0]     rd_addr;
  logic              rd_ok;

  logic signed [DATA_W-1:0]  w_mem [DEPTH];
  logic signed [DATA_W-1:0]  o_mem [OUT_SIZE];
  logic signed [DATA_W-1:0]  e_mem [OUT_SIZE];
  logic signed [DATA_W-1:0]  x_mem [IN_SIZE];
  logic signed [DELTA_W-1:0] d_mem [OUT_SIZE];

  logic signed [DATA_W-1:0]  w_q;
  logic signed [DATA_W-1:0]  o_q;
  logic signed [DATA_W-1:0]  e_q;
  logic signed [DATA_W-1:0]  x_q;
  logic signed [DELTA_W-1:0] d_q;

  logic                      w_we;
  logic [AW-1:0]             w_waddr;
  logic [AW-1:0]             w_raddr;
  logic signed [DATA_W-1:0]  w_wdata;
  logic signed [DATA_W-1:0]  w_upd;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] prod;
  logic signed [MUL_P_W-1:0] prod_r12;
  logic signed [MUL_P_W-1:0] prod_r24;
  logic signed [MUL_A_W-1:0] tmp;
  logic signed [ACC_W-1:0]   acc;
  logic signed [ACC_W-1:0]   acc_r;
  logic signed [MUL_A_W:0]   w_diff;
  logic signed [DATA_W-1:0]  pb_data;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      learning_rate <= LR_RESET;
    end else if (psel && penable && pwrite && pready && paddr == ADDR_LR) begin
      learning_rate <= pwdata[LR_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_LR) ? PDATA_W'(learning_rate) : '0;

  slbp_ctrl #(
    .IN_SIZE  (IN_SIZE),
    .OUT_SIZE (OUT_SIZE)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .command (command),
    .busy    (busy),
    .ctl     (ctl),
    .row_cnt (row_cnt),
    .col_cnt (col_cnt),
    .w_addr  (w_addr)
  );

  // Command decode for the loads, which complete in the accepting cycle.
  always_comb begin
    accept  = start && !busy;
    row_ok  = int'(row) < IN_SIZE;
    col_ok  = int'(col) < OUT_SIZE;
    row_a   = RW'(row);
    col_a   = CW'(col);
    ld_addr = AW'(int'(row) * OUT_SIZE + int'(col));
    ld_w_we = accept && command == CMD_WR_WEIGHT && row_ok && col_ok;
    ld_o_we = accept && command == CMD_WR_OUTPUT && col_ok;
    ld_e_we = accept && command == CMD_WR_ERROR && col_ok;
    ld_x_we = accept && command == CMD_WR_ACT && row_ok;
  end

  always_ff @(posedge clk) begin
    if (accept && command == CMD_RD_WEIGHT) begin
      rd_addr <= ld_addr;
      rd_ok   <= row_ok && col_ok;
    end
  end

  // Weight memory: one write port shared by loads and updates, one read port.
  assign w_we    = ld_w_we || ctl.w_upd_we;
  assign w_waddr = ctl.w_upd_we ? w_addr : ld_addr;
  assign w_wdata = ctl.w_upd_we ? w_upd : value;
  assign w_raddr = ctl.sel_rd ? rd_addr : w_addr;

  always_ff @(posedge clk) begin
    if (w_we) begin
      w_mem[w_waddr] <= w_wdata;
    end
    w_q <= w_mem[w_raddr];
  end

  always_ff @(posedge clk) begin
    if (ld_o_we) begin
      o_mem[col_a] <= value;
    end
    o_q <= o_mem[col_cnt];
  end

  always_ff @(posedge clk) begin
    if (ld_e_we) begin
      e_mem[col_a] <= value;
    end
    e_q <= e_mem[col_cnt];
  end

  always_ff @(posedge clk) begin
    if (ld_x_we) begin
      x_mem[row_a] <= value;
    end
    x_q <= x_mem[row_cnt];
  end

  always_ff @(posedge clk) begin
    if (ctl.d_we) begin
      d_mem[col_cnt] <= prod_r12[DELTA_W-1:0];
    end
    d_q <= d_mem[col_cnt];
  end

  // Operand select for the shared multiplier.
  always_comb begin
    case (ctl.mul_sel)
      MS_E_O: begin
        mul_a = {{(MUL_A_W-DATA_W){e_q[DATA_W-1]}}, e_q};
        mul_b = {{(MUL_B_W-DATA_W){o_q[DATA_W-1]}}, o_q};
      end
      MS_EO_OMC: begin
        mul_a = prod[MUL_A_W-1:0];
        mul_b = ONE_Q12 - {{(MUL_B_W-DATA_W){o_q[DATA_W-1]}}, o_q};
      end
      MS_D_W: begin
        mul_a = d_q;
        mul_b = {{(MUL_B_W-DATA_W){w_q[DATA_W-1]}}, w_q};
      end
      MS_D_X: begin
        mul_a = d_q;
        mul_b = {{(MUL_B_W-DATA_W){x_q[DATA_W-1]}}, x_q};
      end
      MS_P_LR: begin
        mul_a = tmp;
        mul_b = MUL_B_W'(learning_rate);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  slbp_mul u_mul (
    .clk  (clk),
    .en   (ctl.mul_en),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // Round half up is an add of half an LSB followed by an arithmetic shift.
  assign prod_r12 = (prod + HALF_12) >>> 12;
  assign prod_r24 = (prod + HALF_24) >>> 24;

  always_ff @(posedge clk) begin
    if (ctl.tmp_p) begin
      tmp <= prod_r24[MUL_A_W-1:0];
    end else if (ctl.tmp_ch) begin
      tmp <= prod_r12[MUL_A_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.acc_clr) begin
      acc <= '0;
    end else if (ctl.acc_en) begin
      acc <= acc + {{(ACC_W-MUL_P_W){prod[MUL_P_W-1]}}, prod};
    end
  end

  always_comb begin
    acc_r   = (acc + HALF_ACC) >>> 24;
    pb_data = sat16($signed({{(SAT_W-ACC_W){acc_r[ACC_W-1]}}, acc_r}));
    w_diff  = {{(MUL_A_W+1-DATA_W){w_q[DATA_W-1]}}, w_q} - {tmp[MUL_A_W-1], tmp};
    w_upd   = sat16($signed({{(SAT_W-MUL_A_W-1){w_diff[MUL_A_W]}}, w_diff}));
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= ctl.emit_pb || ctl.emit_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit_pb) begin
      kind  <= KIND_PASSBACK;
      index <= IDX_W'(row_cnt);
      data  <= pb_data;
      last  <= (row_cnt == RW'(IN_SIZE - 1));
    end else if (ctl.emit_rd) begin
      kind  <= KIND_WEIGHT;
      index <= '0;
      data  <= rd_ok ? w_q : '0;
      last  <= 1'b0;
    end
  end

  // Loads and updates must never compete for the weight write port.
  `ASSERT_NEVER(a_single_weight_writer, clk, rst, ld_w_we && ctl.w_upd_we)
  // A pass-back element is emitted only right after an accumulation step.
  `ASSERT_CLK(a_passback_after_acc, clk, rst, ctl.emit_pb |-> $past(ctl.acc_en))
  // Only the final pass-back element of a run carries last.
  `ASSERT_CLK(a_last_is_passback, clk, rst, strobe && last |-> kind == KIND_PASSBACK)

endmodule
